[sv/spbf_pkg.sv]
// ----------------------------------------------------------------------------
// spbf_pkg
// Shared types and constants of the stereo pre-delay block FIR equalizer.
// ----------------------------------------------------------------------------
package spbf_pkg;

  localparam int SAMPLE_W = 16;
  localparam int TAP_W    = 18;
  localparam int TAP_AW   = 12;
  localparam int MAX_TAPS = 1 << TAP_AW;
  localparam int CNT_W    = TAP_AW + 1;
  localparam int HIST_AW  = TAP_AW + 1;
  localparam int DLY_AW   = 16;
  localparam int PROD_W   = SAMPLE_W + TAP_W;
  localparam int ACC_W    = PROD_W + TAP_AW;
  localparam int CFG_W    = 16;
  localparam int CIDX_W   = 12;
  localparam int IN_W     = 64;
  localparam int OUT_W    = 2 * SAMPLE_W;

  // Configuration register indexes
  typedef enum logic {
    CFG_TAP_COUNT = 1'b0,
    CFG_PREDELAY  = 1'b1
  } cfg_idx_t;

  // Item kinds carried on tuser
  typedef enum logic {
    KIND_SAMPLE = 1'b0,
    KIND_COEFF  = 1'b1
  } kind_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_TAPW,
    ST_DREAD,
    ST_DWAIT,
    ST_HWRITE,
    ST_MAC,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // Controller to datapath
  typedef struct packed {
    logic cap_in;
    logic clr_step;
    logic tap_wr;
    logic dly_wr;
    logic hist_wr;
    logic mac_clr;
    logic mac_issue;
    logic load_out;
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic dly_on;
    logic fir_on;
    logic mac_last;
    logic clr_last;
    logic out_free;
  } stat_t;

endpackage

[sv/stereo_predelay_block_fir_core.sv]
// ----------------------------------------------------------------------------
// stereo_predelay_block_fir_core
// Stereo pre-delay plus N-tap FIR equalizer with N-sample output delay.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one item per beat: a stereo sample pair (tuser = 0) or a
//   coefficient write (tuser = 1). m_* returns one filtered pair for each
//   sample beat; coefficient beats give no result. cfg_* writes tap_count
//   (index 0) or predelay_length (index 1); the user must write them only
//   while idle, the block itself does not enforce it. A write clears the
//   matching history or delay ring at once. One item is worked at a time.
//   With the filter on, a sample runs one tap per cycle through the shared
//   read/multiply/accumulate pipe, both channels side by side; in plain
//   bypass it goes from IDLE to FINISH and into the output register. The
//   pre-delay ring adds the DREAD and DWAIT states to each sample, and a
//   coefficient beat is written in the TAPW state. s_tready returns in the
//   cycle after the result is loaded. After reset the tap store is cleared
//   by a pass over every entry; s_tready stays low until it ends. A result
//   waits in the output register while m_tready is low; the next item is
//   accepted meanwhile and its result is held until the register frees.
// ----------------------------------------------------------------------------
module stereo_predelay_block_fir_core (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       s_tvalid,
  output logic                       s_tready,
  // left_in[15:0], right_in[31:16], coeff_index[43:32], coeff_value[61:44]
  input  logic [spbf_pkg::IN_W-1:0]  s_tdata,
  // kind[0]
  input  logic [0:0]                 s_tuser,
  output logic                       m_tvalid,
  input  logic                       m_tready,
  // left_out[15:0], right_out[31:16]
  output logic [spbf_pkg::OUT_W-1:0] m_tdata,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [0:0]                 cfg_index,
  input  logic [spbf_pkg::CFG_W-1:0] cfg_data
);
  import spbf_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  assign cfg_ready = 1'b1;

  spbf_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tuser  (s_tuser),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  spbf_datapath u_dp (
    .clk       (clk),
    .rst       (rst),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .s_tdata   (s_tdata),
    .cmd       (cmd),
    .stat      (stat),
    .m_tready  (m_tready),
    .m_tvalid  (m_tvalid),
    .m_tdata   (m_tdata)
  );

endmodule

[sv/spbf_ram.sv]
// ----------------------------------------------------------------------------
// spbf_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spbf_ram #(
  parameter int W     = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [W-1:0]             wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [W-1:0]             rdata
);

  logic [W-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[sv/spbf_datapath.sv]
// ----------------------------------------------------------------------------
// spbf_datapath
// Config registers, pre-delay ring, filter history, tap store, dual MAC
// lanes, rounding and the output register.
// ----------------------------------------------------------------------------
module spbf_datapath (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_valid,
  input  logic [0:0]                  cfg_index,
  input  logic [spbf_pkg::CFG_W-1:0]  cfg_data,
  input  logic [spbf_pkg::IN_W-1:0]   s_tdata,
  input  spbf_pkg::cmd_t              cmd,
  output spbf_pkg::stat_t             stat,
  input  logic                        m_tready,
  output logic                        m_tvalid,
  output logic [spbf_pkg::OUT_W-1:0]  m_tdata
);
  import spbf_pkg::*;

  localparam int Q_W = ACC_W + 1 - (TAP_W - 1);

  logic [CNT_W-1:0]          tap_count;
  logic [DLY_AW-1:0]         dly_len;
  logic [DLY_AW-1:0]         dly_ptr;
  logic                      dly_wrap;
  logic [HIST_AW-1:0]        hist_ptr;
  logic                      hist_wrap;
  logic [SAMPLE_W-1:0]       in_l, in_r;
  logic [CIDX_W-1:0]         in_cidx;
  logic [TAP_W-1:0]          in_cval;
  logic [SAMPLE_W-1:0]       x_l, x_r;
  logic [TAP_AW-1:0]         j;
  logic [TAP_AW-1:0]         clr_cnt;
  logic                      iss1, iss2, v1;
  logic signed [PROD_W-1:0]  prod_l, prod_r;
  logic signed [ACC_W-1:0]   acc_l, acc_r;
  logic [OUT_W-1:0]          dly_rdata, hist_rdata;
  logic [TAP_W-1:0]          tap_rdata;
  logic [HIST_AW:0]          lag;
  logic [HIST_AW-1:0]        hist_raddr;
  logic                      v0;
  logic signed [SAMPLE_W-1:0] sl, sr;
  logic signed [TAP_W-1:0]   tr;
  logic                      tap_we;
  logic [TAP_AW-1:0]         tap_waddr;
  logic [TAP_W-1:0]          tap_wdata;
  logic                      cfg_tap_wr, cfg_dly_wr;

  // Round half up at bit 16, floor shift, saturate to sample width
  function automatic logic [SAMPLE_W-1:0] round_sat(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W:0] biased;
    logic [Q_W-1:0]        q;
    logic                  fits;
    biased = $signed({a[ACC_W-1], a})
           + $signed({{(ACC_W - TAP_W + 2){1'b0}}, 1'b1, {(TAP_W - 2){1'b0}}});
    q      = biased[ACC_W:TAP_W-1];
    fits   = (&q[Q_W-1:SAMPLE_W-1]) || !(|q[Q_W-1:SAMPLE_W-1]);
    if (fits) begin
      round_sat = q[SAMPLE_W-1:0];
    end else if (q[Q_W-1]) begin
      round_sat = {1'b1, {(SAMPLE_W-1){1'b0}}};
    end else begin
      round_sat = {1'b0, {(SAMPLE_W-1){1'b1}}};
    end
  endfunction

  assign cfg_tap_wr = cfg_valid && (cfg_idx_t'(cfg_index) == CFG_TAP_COUNT);
  assign cfg_dly_wr = cfg_valid && (cfg_idx_t'(cfg_index) == CFG_PREDELAY);

  // Config registers, clamp tap count to the store size
  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count <= '0;
      dly_len   <= '0;
    end else begin
      if (cfg_tap_wr) begin
        tap_count <= (cfg_data[CNT_W-1:0] > CNT_W'(MAX_TAPS)) ? CNT_W'(MAX_TAPS)
                                                              : cfg_data[CNT_W-1:0];
      end
      if (cfg_dly_wr) begin
        dly_len <= cfg_data[DLY_AW-1:0];
      end
    end
  end

  // Pre-delay pointer; ring reads are zero until the first wrap
  always_ff @(posedge clk) begin
    if (rst || cfg_dly_wr) begin
      dly_ptr  <= '0;
      dly_wrap <= 1'b0;
    end else if (cmd.dly_wr) begin
      if (({1'b0, dly_ptr} + (DLY_AW+1)'(1)) >= {1'b0, dly_len}) begin
        dly_ptr  <= '0;
        dly_wrap <= 1'b1;
      end else begin
        dly_ptr <= dly_ptr + DLY_AW'(1);
      end
    end
  end

  // History pointer; advance when a filtered result leaves
  always_ff @(posedge clk) begin
    if (rst || cfg_tap_wr) begin
      hist_ptr  <= '0;
      hist_wrap <= 1'b0;
    end else if (cmd.load_out && stat.fir_on) begin
      hist_ptr <= hist_ptr + HIST_AW'(1);
      if (&hist_ptr) begin
        hist_wrap <= 1'b1;
      end
    end
  end

  // Capture the input beat, then swap in the delayed sample
  always_ff @(posedge clk) begin
    if (cmd.cap_in) begin
      in_l    <= s_tdata[SAMPLE_W-1:0];
      in_r    <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
      in_cidx <= s_tdata[2*SAMPLE_W+CIDX_W-1:2*SAMPLE_W];
      in_cval <= s_tdata[2*SAMPLE_W+CIDX_W+TAP_W-1:2*SAMPLE_W+CIDX_W];
      x_l     <= s_tdata[SAMPLE_W-1:0];
      x_r     <= s_tdata[2*SAMPLE_W-1:SAMPLE_W];
    end else if (cmd.dly_wr) begin
      x_l <= dly_wrap ? dly_rdata[SAMPLE_W-1:0] : '0;
      x_r <= dly_wrap ? dly_rdata[OUT_W-1:SAMPLE_W] : '0;
    end
  end

  spbf_ram #(.W(OUT_W), .DEPTH(1 << DLY_AW)) u_dly_ram (
    .clk   (clk),
    .we    (cmd.dly_wr),
    .waddr (dly_ptr),
    .wdata ({in_r, in_l}),
    .raddr (dly_ptr),
    .rdata (dly_rdata)
  );

  // History read address: newest minus (N + j); valid if already written
  assign lag        = {1'b0, tap_count} + {2'b00, j};
  assign hist_raddr = hist_ptr - lag[HIST_AW-1:0];
  assign v0         = hist_wrap || ({1'b0, hist_ptr} >= lag);

  spbf_ram #(.W(OUT_W), .DEPTH(1 << HIST_AW)) u_hist_ram (
    .clk   (clk),
    .we    (cmd.hist_wr),
    .waddr (hist_ptr),
    .wdata ({x_r, x_l}),
    .raddr (hist_raddr),
    .rdata (hist_rdata)
  );

  // Tap store: clearing pass after reset, else coefficient writes
  assign tap_we    = cmd.clr_step || cmd.tap_wr;
  assign tap_waddr = cmd.clr_step ? clr_cnt : in_cidx;
  assign tap_wdata = cmd.clr_step ? '0 : in_cval;

  spbf_ram #(.W(TAP_W), .DEPTH(MAX_TAPS)) u_tap_ram (
    .clk   (clk),
    .we    (tap_we),
    .waddr (tap_waddr),
    .wdata (tap_wdata),
    .raddr (j),
    .rdata (tap_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt <= '0;
    end else if (cmd.clr_step) begin
      clr_cnt <= clr_cnt + TAP_AW'(1);
    end
  end

  // Tap counter and issue pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      j    <= '0;
      iss1 <= 1'b0;
      iss2 <= 1'b0;
    end else begin
      iss1 <= cmd.mac_issue;
      iss2 <= iss1;
      if (cmd.mac_clr) begin
        j <= '0;
      end else if (cmd.mac_issue) begin
        j <= j + TAP_AW'(1);
      end
    end
  end

  assign sl = v1 ? $signed(hist_rdata[SAMPLE_W-1:0]) : '0;
  assign sr = v1 ? $signed(hist_rdata[OUT_W-1:SAMPLE_W]) : '0;
  assign tr = $signed(tap_rdata);

  // Multiply stage then accumulate
  always_ff @(posedge clk) begin
    v1     <= v0;
    prod_l <= sl * tr;
    prod_r <= sr * tr;
    if (cmd.mac_clr) begin
      acc_l <= '0;
      acc_r <= '0;
    end else if (iss2) begin
      acc_l <= acc_l + $signed({{(ACC_W-PROD_W){prod_l[PROD_W-1]}}, prod_l});
      acc_r <= acc_r + $signed({{(ACC_W-PROD_W){prod_r[PROD_W-1]}}, prod_r});
    end
  end

  // Output register; hold while stalled
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (cmd.load_out) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      m_tdata <= stat.fir_on ? {round_sat(acc_r), round_sat(acc_l)} : {x_r, x_l};
    end
  end

  assign stat.dly_on   = (dly_len != '0);
  assign stat.fir_on   = (tap_count != '0);
  assign stat.mac_last = (({1'b0, j} + CNT_W'(1)) == tap_count);
  assign stat.clr_last = &clr_cnt;
  assign stat.out_free = !m_tvalid || m_tready;

endmodule

[sv/spbf_ctrl.sv]
// ----------------------------------------------------------------------------
// spbf_ctrl
// Sequencer: tap clearing pass, item decode, pre-delay, MAC loop, result.
// ----------------------------------------------------------------------------
module spbf_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  input  logic [0:0]      s_tuser,
  output logic            s_tready,
  input  spbf_pkg::stat_t stat,
  output spbf_pkg::cmd_t  cmd
);
  import spbf_pkg::*;

  state_t state, state_next;
  logic   drain, drain_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
      drain <= 1'b0;
    end else begin
      state <= state_next;
      drain <= drain_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    drain_next = drain;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (stat.clr_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.cap_in = 1'b1;
          if (kind_t'(s_tuser) == KIND_COEFF) begin
            state_next = ST_TAPW;
          end else if (stat.dly_on) begin
            state_next = ST_DREAD;
          end else if (stat.fir_on) begin
            state_next = ST_HWRITE;
          end else begin
            state_next = ST_FINISH;
          end
        end
      end
      ST_TAPW: begin
        cmd.tap_wr = 1'b1;
        state_next = ST_IDLE;
      end
      ST_DREAD: begin
        state_next = ST_DWAIT;
      end
      ST_DWAIT: begin
        cmd.dly_wr = 1'b1;
        state_next = stat.fir_on ? ST_HWRITE : ST_FINISH;
      end
      ST_HWRITE: begin
        cmd.hist_wr = 1'b1;
        cmd.mac_clr = 1'b1;
        state_next  = ST_MAC;
      end
      ST_MAC: begin
        cmd.mac_issue = 1'b1;
        if (stat.mac_last) begin
          drain_next = 1'b0;
          state_next = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        // wait out read and multiply stages
        drain_next = 1'b1;
        if (drain) begin
          drain_next = 1'b0;
          state_next = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.load_out = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

[sv/spbf_checker.sv]
// ----------------------------------------------------------------------------
// spbf_checker
// Port-level checks on the equalizer core, bound to the top level.
// ----------------------------------------------------------------------------
module spbf_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       s_tvalid,
  input logic                       s_tready,
  input logic [0:0]                 s_tuser,
  input logic                       m_tvalid,
  input logic                       m_tready,
  input logic [spbf_pkg::OUT_W-1:0] m_tdata
);
  import spbf_pkg::*;

  // Reset empties the output and starts the clearing pass
  a_reset: assert property (@(posedge clk) rst |=> !m_tvalid && !s_tready)
    else $error("output valid or input ready after reset");

  // Stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result beat changed");

  // One item in work at a time
  a_single: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("input taken while an item is in work");

  // A coefficient beat gives no result
  a_coeff: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == KIND_COEFF) |=> !$rose(m_tvalid))
    else $error("result after coefficient beat");

endmodule

bind stereo_predelay_block_fir_core spbf_checker u_spbf_checker (.*);

[tb/tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the stereo pre-delay block FIR equalizer. A
// directed table covers bypass extremes and tap loads. Random phases then
// sweep tap counts and pre-delay lengths, and every output beat is compared
// with an in-bench predictor of the delay ring and the delayed FIR.
// ----------------------------------------------------------------------------
module tb;
  import spbf_pkg::*;

  typedef struct {
    kind_t       kind;
    logic [15:0] left;
    logic [15:0] right;
    logic [11:0] cidx;
    logic [17:0] cval;
    bit          typed;
    logic [15:0] want_l;
    logic [15:0] want_r;
  } beat_t;

  typedef struct {
    logic [15:0] l;
    logic [15:0] r;
  } pair_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [63:0] s_tdata = '0;
  logic [0:0]  s_tuser = '0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [0:0]  cfg_index = '0;
  logic [15:0] cfg_data = '0;

  // Predictor state
  logic signed [17:0] tap_mem [MAX_TAPS];
  logic signed [15:0] hist_l [2*MAX_TAPS];
  logic signed [15:0] hist_r [2*MAX_TAPS];
  logic signed [15:0] ring_l [65536];
  logic signed [15:0] ring_r [65536];
  int unsigned hist_ptr, ring_ptr, n_taps, ring_len;

  pair_t       pending_q[$];
  int          mismatches = 0;
  int          n_results = 0;
  int          n_beats = 0;
  bit          no_idle = 1'b0;
  int          stall_left = 0;

  stereo_predelay_block_fir_core u_dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  // One channel of the delayed FIR: y[n] = sum h[j]*x[n-N-j], rounded, saturated
  function automatic logic signed [15:0] fir_out(bit right_ch, int unsigned newest);
    longint acc;
    int unsigned idx;
    acc = 0;
    for (int unsigned j = 0; j < n_taps; j++) begin
      idx = (newest + 4*MAX_TAPS - n_taps - j) % (2*MAX_TAPS);
      acc += longint'(right_ch ? hist_r[idx] : hist_l[idx]) * longint'(tap_mem[j]);
    end
    acc = (acc + (longint'(1) << 16)) >>> 17;
    if (acc > 32767) acc = 32767;
    else if (acc < -32768) acc = -32768;
    return 16'(acc);
  endfunction

  // Advance predictor by one accepted beat; returns 1 when a result is due
  function automatic bit eq_step(beat_t b, output pair_t res);
    logic signed [15:0] l, r, t;
    int unsigned hp;
    l = b.left;
    r = b.right;
    res = '{16'd0, 16'd0};
    if (b.kind == KIND_COEFF) begin
      tap_mem[b.cidx] = b.cval;
      return 1'b0;
    end
    if (ring_len != 0) begin
      if (ring_ptr >= ring_len) ring_ptr = 0;
      t = ring_l[ring_ptr]; ring_l[ring_ptr] = l; l = t;
      t = ring_r[ring_ptr]; ring_r[ring_ptr] = r; r = t;
      ring_ptr++;
      if (ring_ptr >= ring_len) ring_ptr = 0;
    end
    if (n_taps != 0) begin
      hp = hist_ptr % (2*MAX_TAPS);
      hist_l[hp] = l;
      hist_r[hp] = r;
      l = fir_out(1'b0, hp);
      r = fir_out(1'b1, hp);
      hist_ptr = (hp + 1) % (2*MAX_TAPS);
    end
    res = '{l, r};
    return 1'b1;
  endfunction

  // Output side: random stalls, compare each beat with the oldest expectation
  always @(posedge clk) begin
    pair_t e;
    if (!rst && m_tvalid && m_tready) begin
      n_results++;
      if (pending_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected output beat %h", m_tdata);
      end else begin
        e = pending_q.pop_front();
        if (m_tdata[15:0] !== e.l || m_tdata[31:16] !== e.r) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: left exp %h got %h, right exp %h got %h",
                     e.l, m_tdata[15:0], e.r, m_tdata[31:16]);
        end
      end
    end
    if (m_tvalid && m_tready) stall_left = no_idle ? 0 : $urandom_range(0, 8);
    if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Drive one item, hold until accepted, then predict
  task automatic send_beat(beat_t b);
    int gap;
    pair_t res;
    gap = no_idle ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= b.kind;
    s_tdata  <= {2'b00, b.cval, b.cidx, b.right, b.left};
    do @(posedge clk); while (!s_tready);
    n_beats++;
    if (eq_step(b, res)) pending_q.push_back(b.typed ? pair_t'{b.want_l, b.want_r} : res);
  endtask

  // Let all results arrive, then cover the tail of a coefficient beat
  task automatic drain();
    s_tvalid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (n_taps + 20) @(posedge clk);
  endtask

  task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
    int unsigned v;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_TAP_COUNT) begin
      v = val[12:0];
      n_taps = (v > MAX_TAPS) ? MAX_TAPS : v;
      foreach (hist_l[i]) begin hist_l[i] = 0; hist_r[i] = 0; end
      hist_ptr = 0;
    end else begin
      ring_len = val;
      foreach (ring_l[i]) begin ring_l[i] = 0; ring_r[i] = 0; end
      ring_ptr = 0;
    end
  endtask

  function automatic beat_t sample(logic [15:0] l, logic [15:0] r);
    beat_t b;
    b = '{KIND_SAMPLE, l, r, 12'($urandom), 18'($urandom), 1'b0, 16'd0, 16'd0};
    return b;
  endfunction

  function automatic beat_t coeff(logic [11:0] i, logic [17:0] v);
    beat_t b;
    b = '{KIND_COEFF, 16'($urandom), 16'($urandom), i, v, 1'b0, 16'd0, 16'd0};
    return b;
  endfunction

  function automatic logic [15:0] rand_sample();
    case ($urandom_range(0, 5))
      0: return 16'h7fff;
      1: return 16'h8000;
      default: return 16'($urandom);
    endcase
  endfunction

  // Random mix: mostly samples, some tap loads near the active taps
  task automatic random_phase(int count);
    beat_t b;
    for (int k = 0; k < count; k++) begin
      if ($urandom_range(0, 3) == 0)
        b = coeff($urandom_range(0, 1) ? 12'($urandom_range(0, 15)) : 12'($urandom),
                  $urandom_range(0, 4) == 0 ? 18'h1ffff : 18'($urandom));
      else
        b = sample(rand_sample(), rand_sample());
      send_beat(b);
    end
  endtask

  beat_t dir_tab[$];

  initial begin
    n_taps = 0; ring_len = 0; hist_ptr = 0; ring_ptr = 0;
    foreach (tap_mem[i]) tap_mem[i] = 0;
    foreach (hist_l[i]) begin hist_l[i] = 0; hist_r[i] = 0; end
    foreach (ring_l[i]) begin ring_l[i] = 0; ring_r[i] = 0; end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Bypass after reset: output equals input; tap loads give no result
    dir_tab = '{
      '{KIND_SAMPLE, 16'h7fff, 16'h8000, 12'h000, 18'h00000, 1'b1, 16'h7fff, 16'h8000},
      '{KIND_SAMPLE, 16'h8000, 16'h7fff, 12'hfff, 18'h3ffff, 1'b1, 16'h8000, 16'h7fff},
      '{KIND_SAMPLE, 16'h0000, 16'hffff, 12'h555, 18'h2aaaa, 1'b1, 16'h0000, 16'hffff},
      '{KIND_SAMPLE, 16'hffff, 16'h0000, 12'haaa, 18'h15555, 1'b1, 16'hffff, 16'h0000},
      '{KIND_SAMPLE, 16'h5555, 16'haaaa, 12'h000, 18'h00000, 1'b1, 16'h5555, 16'haaaa},
      '{KIND_COEFF,  16'hffff, 16'hffff, 12'h000, 18'h1ffff, 1'b0, 16'h0000, 16'h0000},
      '{KIND_COEFF,  16'h0000, 16'h0000, 12'hfff, 18'h20000, 1'b0, 16'h0000, 16'h0000},
      '{KIND_COEFF,  16'h1234, 16'h5678, 12'h001, 18'h3ffff, 1'b0, 16'h0000, 16'h0000},
      '{KIND_SAMPLE, 16'h0001, 16'hfffe, 12'hfff, 18'h3ffff, 1'b1, 16'h0001, 16'hfffe}
    };
    foreach (dir_tab[i]) send_beat(dir_tab[i]);
    drain();

    // Saturation both ways: all taps at full scale, full-scale input
    write_reg(CFG_TAP_COUNT, 16'd8);
    write_reg(CFG_PREDELAY, 16'd3);
    for (int j = 0; j < 8; j++) send_beat(coeff(12'(j), 18'h1ffff));
    for (int k = 0; k < 7; k++) send_beat(sample(16'h7fff, 16'h8000));
    for (int k = 0; k < 7; k++) send_beat(sample(16'h8000, 16'h7fff));
    drain();

    // Random phases over several settings, one without any idling
    write_reg(CFG_TAP_COUNT, 16'd5);
    write_reg(CFG_PREDELAY, 16'd1);
    random_phase(20);
    drain();
    write_reg(CFG_TAP_COUNT, 16'd16);
    write_reg(CFG_PREDELAY, 16'd7);
    no_idle = 1'b1;
    random_phase(20);
    no_idle = 1'b0;
    random_phase(15);
    drain();
    write_reg(CFG_TAP_COUNT, 16'd0);
    write_reg(CFG_PREDELAY, 16'hffff);
    random_phase(8);
    drain();
    write_reg(CFG_TAP_COUNT, 16'hffff);
    write_reg(CFG_PREDELAY, 16'd0);
    random_phase(5);
    drain();
    write_reg(CFG_TAP_COUNT, 16'd8);
    write_reg(CFG_PREDELAY, 16'd2);
    random_phase(10);
    drain();
    random_phase(10);
    drain();

    $display("covered %0d input beats and %0d output beats over bypass, pre-delay,",
             n_beats, n_results);
    $display("tap counts 0 to 4096 with saturation and mid-run tap loads");
    if (mismatches == 0 && pending_q.size() == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("%0d mismatches, %0d results missing", mismatches, pending_q.size());
      $display("CHECKS FAILED");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("timeout with %0d results outstanding", pending_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule
